// ----- rtl/pac_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pac_pkg
// Types, constants and helpers shared by the profile alignment cell.
// ----------------------------------------------------------------------------
package pac_pkg;

    localparam int LANES       = 5;
    localparam int COUNT_W     = 4;
    localparam int SCORE_W     = 24;
    localparam int COEF_W      = 12;
    localparam int ROW_W       = 60;
    localparam int PROF_W      = LANES * COUNT_W;
    localparam int CFG_IDX_W   = 3;
    localparam int NORM_W      = 8;
    localparam int DIV_STEPS   = SCORE_W;

    localparam logic [CFG_IDX_W-1:0] REG_ROW0 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ROW1 = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_ROW2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_ROW3 = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_ROW4 = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_GAP = CFG_IDX_W'(LANES);
    localparam logic signed [SCORE_W-1:0] GAP_RESET = -SCORE_W'(256);

    typedef enum logic [1:0] {
        DIR_UP   = 2'd0,
        DIR_DIAG = 2'd1,
        DIR_LEFT = 2'd2
    } dir_t;

    typedef struct packed {
        logic [PROF_W-1:0]         query_profile;
        logic [PROF_W-1:0]         reference_profile;
        logic signed [SCORE_W-1:0] up_score;
        logic signed [SCORE_W-1:0] diag_score;
        logic signed [SCORE_W-1:0] left_score;
    } in_item_t;

    typedef struct packed {
        logic signed [SCORE_W-1:0] best_score;
        logic [1:0]                direction;
    } out_item_t;

    // match divider state carried down the pipeline
    typedef struct packed {
        logic                      neg;
        logic                      active;
        logic [SCORE_W-1:0]        dvd;
        logic [SCORE_W-1:0]        rem;
        logic [NORM_W-1:0]         dvs;
        logic signed [SCORE_W-1:0] up_score;
        logic signed [SCORE_W-1:0] diag_score;
        logic signed [SCORE_W-1:0] left_score;
    } div_t;

endpackage

// ----- rtl/pac_div_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pac_div_stage
// One registered restoring division step on magnitudes, with pipeline hold.
// ----------------------------------------------------------------------------
module pac_div_stage import pac_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic adv,
    input  logic vin,
    input  div_t din,
    output logic vout,
    output div_t dout
);
    logic        v_reg;
    div_t        d_reg, d_next;
    logic [SCORE_W:0] trial;

    always_comb begin
        d_next = din;
        trial  = {din.rem, din.dvd[SCORE_W-1]} - {{(SCORE_W-NORM_W+1){1'b0}}, din.dvs};
        if (!trial[SCORE_W]) begin
            d_next.rem = trial[SCORE_W-1:0];
            d_next.dvd = {din.dvd[SCORE_W-2:0], 1'b1};
        end else begin
            d_next.rem = {din.rem[SCORE_W-2:0], din.dvd[SCORE_W-1]};
            d_next.dvd = {din.dvd[SCORE_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (adv) begin
            v_reg <= vin;
        end
        if (adv) begin
            d_reg <= d_next;
        end
    end

    assign vout = v_reg;
    assign dout = d_reg;
endmodule

// ----- rtl/profile_alignment_cell_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// profile_alignment_cell_core
// Profile-to-profile alignment DP cell with linear gap.
// ----------------------------------------------------------------------------
// Accepts one transaction per cycle while the output is not stalled.
// Stages: partial rows, match sum, divide setup, 24 division steps, floor and add, select.
// The division steps set the depth; a stalled output holds the whole pipeline.
// Reset clears all valid bits, transition rows to zero and the gap score to -256.
module profile_alignment_cell_core import pac_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ROW_W-1:0]     cfg_data
);
    logic [ROW_W-1:0]          rows_reg [LANES];
    logic signed [SCORE_W-1:0] gap_reg;
    logic                      adv;

    assign cfg_ready = 1'b1;
    assign adv       = !m_valid || m_ready;
    assign s_ready   = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < LANES; k++) rows_reg[k] <= '0;
            gap_reg <= GAP_RESET;
        end else if (cfg_valid) begin
            if (cfg_index < REG_GAP) begin
                rows_reg[cfg_index] <= cfg_data;
            end else if (cfg_index == REG_GAP) begin
                gap_reg <= cfg_data[SCORE_W-1:0];
            end
        end
    end

    // stage 1: per-column partial sums and column sums
    logic                      v1_reg;
    logic signed [SCORE_W-1:0] part_reg [LANES];
    logic [PROF_W-1:0]         r1_reg;
    logic [NORM_W-1:0]         qs1_reg, rs1_reg;
    logic signed [SCORE_W-1:0] up1_reg, dg1_reg, lf1_reg;
    logic signed [SCORE_W-1:0] part_next [LANES];
    logic [NORM_W-1:0]         qs_next, rs_next;

    always_comb begin
        qs_next = '0;
        rs_next = '0;
        for (int i = 0; i < LANES; i++) begin
            part_next[i] = '0;
            for (int j = 0; j < LANES; j++) begin
                part_next[i] = part_next[i]
                    + SCORE_W'(signed'({1'b0, s_data.query_profile[j*COUNT_W +: COUNT_W]})
                      * SCORE_W'(signed'(rows_reg[j][i*COEF_W +: COEF_W])));
            end
            qs_next = qs_next + NORM_W'(s_data.query_profile[i*COUNT_W +: COUNT_W]);
            rs_next = rs_next + NORM_W'(s_data.reference_profile[i*COUNT_W +: COUNT_W]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
        end
        if (adv) begin
            part_reg <= part_next;
            r1_reg   <= s_data.reference_profile;
            qs1_reg  <= qs_next;
            rs1_reg  <= rs_next;
            up1_reg  <= s_data.up_score;
            dg1_reg  <= s_data.diag_score;
            lf1_reg  <= s_data.left_score;
        end
    end

    // stage 2: match sum and normaliser
    logic                      v2_reg;
    logic signed [SCORE_W-1:0] match2_reg;
    logic signed [NORM_W-1:0]  norm2_reg;
    logic signed [SCORE_W-1:0] up2_reg, dg2_reg, lf2_reg;
    logic signed [SCORE_W-1:0] match_next;
    logic [2*NORM_W-1:0]       prod;

    always_comb begin
        match_next = '0;
        for (int i = 0; i < LANES; i++) begin
            match_next = match_next + SCORE_W'(part_reg[i]
                * SCORE_W'(signed'({1'b0, r1_reg[i*COUNT_W +: COUNT_W]})));
        end
        prod = qs1_reg * rs1_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
        end
        if (adv) begin
            match2_reg <= match_next;
            norm2_reg  <= prod[NORM_W-1:0];
            up2_reg    <= up1_reg;
            dg2_reg    <= dg1_reg;
            lf2_reg    <= lf1_reg;
        end
    end

    // stage 3: magnitudes for the divider
    logic v3_reg;
    div_t d3_reg, d3_next;
    logic [SCORE_W-1:0] mag_m;
    logic [NORM_W-1:0]  mag_n;

    always_comb begin
        mag_m = match2_reg[SCORE_W-1] ? SCORE_W'(-match2_reg) : match2_reg;
        mag_n = norm2_reg[NORM_W-1] ? NORM_W'(-norm2_reg) : norm2_reg;
        d3_next.neg        = match2_reg[SCORE_W-1] ^ norm2_reg[NORM_W-1];
        d3_next.active     = (norm2_reg != '0);
        d3_next.dvd        = (norm2_reg != '0) ? mag_m : match2_reg;
        d3_next.rem        = '0;
        d3_next.dvs        = (norm2_reg != '0) ? mag_n : NORM_W'(1);
        d3_next.up_score   = up2_reg;
        d3_next.diag_score = dg2_reg;
        d3_next.left_score = lf2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= v2_reg;
        end
        if (adv) begin
            d3_reg <= d3_next;
        end
    end

    logic dv [DIV_STEPS+1];
    div_t dd [DIV_STEPS+1];
    assign dv[0] = v3_reg;
    assign dd[0] = d3_reg;

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        pac_div_stage u_step (
            .aclk (aclk),
            .aresetn (aresetn),
            .adv  (adv),
            .vin  (dv[g]),
            .din  (dd[g]),
            .vout (dv[g+1]),
            .dout (dd[g+1])
        );
    end

    // quotient fix-up for floor, then add scores
    logic                      v4_reg;
    logic signed [SCORE_W-1:0] del4_reg, dia4_reg, ins4_reg;
    logic signed [SCORE_W-1:0] quo, mt;
    div_t                      dz;

    always_comb begin
        dz  = dd[DIV_STEPS];
        quo = dz.neg ? SCORE_W'(-dz.dvd - ((dz.rem != '0) ? 1 : 0)) : dz.dvd;
        mt  = dz.active ? quo : dz.dvd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (adv) begin
            v4_reg <= dv[DIV_STEPS];
        end
        if (adv) begin
            del4_reg <= dz.up_score + gap_reg;
            dia4_reg <= dz.diag_score + mt;
            ins4_reg <= dz.left_score + gap_reg;
        end
    end

    // select and output register
    logic      vo_reg;
    out_item_t o_reg, o_next;

    always_comb begin
        o_next.best_score = del4_reg;
        o_next.direction  = DIR_UP;
        if (del4_reg < dia4_reg) begin
            o_next.best_score = dia4_reg;
            o_next.direction  = DIR_DIAG;
        end
        if (o_next.best_score < ins4_reg) begin
            o_next.best_score = ins4_reg;
            o_next.direction  = DIR_LEFT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vo_reg <= 1'b0;
        end else if (adv) begin
            vo_reg <= v4_reg;
        end
        if (adv) begin
            o_reg <= o_next;
        end
    end

    assign m_valid = vo_reg;
    assign m_data  = o_reg;

`ifndef SYNTHESIS
    a_dir_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.direction != 2'd3))
        else $error("bad direction");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("output not held");
    a_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        (v4_reg && adv) |=> m_valid)
        else $error("result lost");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("stall without result");
`endif
endmodule
